>>> src/tcpct_pkg.sv
package tcpct_pkg;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int HANDLE_W = 6;

	// operation codes carried by the kind field
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLOSE  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_FREE = 2'd3
	} status_t;

	// connection endpoints, broadcast to every cell
	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} key_t;

	// search wave passed from cell to cell
	typedef struct packed {
		logic live;
		logic hit;
	} wave_t;

	// table update broadcast at the end of an item
	typedef struct packed {
		logic strobe;
		op_t  op;
	} cmd_t;

endpackage

>>> src/tcpct_cell.sv
module tcpct_cell
	import tcpct_pkg::*;
#(
	parameter int IDX_W = 6,
	parameter int INDEX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  op_t              op,
	input  key_t             key,
	input  logic [5:0]       close_handle,
	input  wave_t            wave_in,
	input  logic [IDX_W-1:0] idx_in,
	input  logic [IDX_W-1:0] rank_in,
	output wave_t            wave_out,
	output logic [IDX_W-1:0] idx_out,
	output logic [IDX_W-1:0] rank_out,
	input  cmd_t             cmd,
	input  logic [IDX_W-1:0] cmd_idx,
	input  logic [IDX_W-1:0] cmd_rank
);

	logic             valid_q;
	key_t             key_q;
	logic [IDX_W-1:0] rank_q;

	wave_t            wave_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] rank_wq;

	logic fwd, rev, take, is_me;

	// endpoint match in either direction
	assign fwd = (key_q.src_ip == key.src_ip) && (key_q.src_port == key.src_port) &&
		(key_q.dst_ip == key.dst_ip) && (key_q.dst_port == key.dst_port);
	assign rev = (key_q.src_ip == key.dst_ip) && (key_q.src_port == key.dst_port) &&
		(key_q.dst_ip == key.src_ip) && (key_q.dst_port == key.src_port);

	// does this cell claim the wave
	always_comb begin
		take = 1'b0;
		case (op)
			OP_INSERT: take = !valid_q && !wave_in.hit;
			OP_LOOKUP: take = valid_q && (fwd || rev) &&
				(!wave_in.hit || (rank_q < rank_in));
			OP_CLOSE: take = valid_q && (int'(close_handle) == INDEX);
			default: take = 1'b0;
		endcase
	end

	// pass the wave to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q.live <= wave_in.live;
			wave_q.hit  <= wave_in.hit || take;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= take ? IDX_W'(INDEX) : idx_in;
		rank_wq <= take ? rank_q : rank_in;
	end

	assign wave_out = wave_q;
	assign idx_out  = idx_q;
	assign rank_out = rank_wq;

	assign is_me = (cmd_idx == IDX_W'(INDEX));

	// entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.strobe && is_me) begin
			if (cmd.op == OP_INSERT) begin
				valid_q <= 1'b1;
			end else if (cmd.op == OP_CLOSE) begin
				valid_q <= 1'b0;
			end
		end
	end

	// entry key and recency rank
	always_ff @(posedge clk) begin
		if (cmd.strobe) begin
			if (cmd.op == OP_INSERT) begin
				if (is_me) begin
					key_q  <= key;
					rank_q <= '0;
				end else if (valid_q) begin
					rank_q <= rank_q + 1'b1;
				end
			end else if (cmd.op == OP_CLOSE) begin
				if (!is_me && valid_q && (rank_q > cmd_rank)) begin
					rank_q <= rank_q - 1'b1;
				end
			end
		end
	end

endmodule

>>> src/tcp_connection_table.sv
// channel | signals                                              | accepted when
// --------+------------------------------------------------------+----------------------
// in      | in_valid, in_stall, kind, src_ip, dst_ip, src_port,  | in_valid && !in_stall
//         | dst_port, close_handle                               |
// out     | out_valid, out_stall, status, result_handle          | out_valid && !out_stall
//
// one item passes through these steps: the launch register starts the search wave, the
// wave walks the cell row through the register of each cell, the finish step updates the table and
// loads the result register, and the sequencer returns to idle; in_stall is high outside idle
// the next item is taken while a finished result still sits in the output register
// a stalled output holds the update back until the result register frees up
// reset clears all valid bits at once; no clearing pass
module tcp_connection_table
	import tcpct_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [31:0]         src_ip,
	input  logic [31:0]         dst_ip,
	input  logic [15:0]         src_port,
	input  logic [15:0]         dst_port,
	input  logic [5:0]          close_handle,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [HANDLE_W-1:0] result_handle
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_FINISH
	} state_t;

	state_t           state_q;
	op_t              op_q;
	key_t             key_q;
	logic [5:0]       handle_q;
	logic             launch_q;
	logic             hit_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] rank_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [HANDLE_W-1:0] result_q;

	wave_t            wave [TABLE_DEPTH+1];
	logic [IDX_W-1:0] widx [TABLE_DEPTH+1];
	logic [IDX_W-1:0] wrank [TABLE_DEPTH+1];

	cmd_t             cmd;
	logic             out_free;
	logic             in_take;
	status_t          status_d;
	logic [HANDLE_W-1:0] result_d;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// wave head
	assign wave[0].live = launch_q;
	assign wave[0].hit  = 1'b0;
	assign widx[0]      = '0;
	assign wrank[0]     = '0;

	// table update for a successful insert or close, once the result can be stored
	assign cmd.strobe = (state_q == S_FINISH) && out_free && hit_q &&
		((op_q == OP_INSERT) || (op_q == OP_CLOSE));
	assign cmd.op     = op_q;

	// row of table cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		tcpct_cell #(
			.IDX_W (IDX_W),
			.INDEX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.op           (op_q),
			.key          (key_q),
			.close_handle (handle_q),
			.wave_in      (wave[i]),
			.idx_in       (widx[i]),
			.rank_in      (wrank[i]),
			.wave_out     (wave[i+1]),
			.idx_out      (widx[i+1]),
			.rank_out     (wrank[i+1]),
			.cmd          (cmd),
			.cmd_idx      (idx_q),
			.cmd_rank     (rank_q)
		);
	end

	// result of the finished search
	always_comb begin
		status_d = ST_OK;
		result_d = '0;
		case (op_q)
			OP_INSERT: status_d = hit_q ? ST_OK : ST_FULL;
			OP_LOOKUP: status_d = hit_q ? ST_OK : ST_MISS;
			OP_CLOSE:  status_d = hit_q ? ST_OK : ST_FREE;
			default:   status_d = ST_OK;
		endcase
		if (hit_q && (op_q != OP_NOP)) begin
			result_d = HANDLE_W'(idx_q);
		end
	end

	// control sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
			op_q        <= OP_NOP;
			key_q       <= '0;
			handle_q    <= '0;
			hit_q       <= 1'b0;
			idx_q       <= '0;
			rank_q      <= '0;
			status_q    <= ST_OK;
			result_q    <= '0;
		end else begin
			launch_q <= in_take;
			// load a new result or drop the one taken by the receiver
			if ((state_q == S_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						op_q              <= op_t'(kind);
						key_q.src_ip      <= src_ip;
						key_q.dst_ip      <= dst_ip;
						key_q.src_port    <= src_port;
						key_q.dst_port    <= dst_port;
						handle_q          <= close_handle;
						state_q           <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (wave[TABLE_DEPTH].live) begin
						hit_q   <= wave[TABLE_DEPTH].hit;
						idx_q   <= widx[TABLE_DEPTH];
						rank_q  <= wrank[TABLE_DEPTH];
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						status_q    <= status_d;
						result_q    <= result_d;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_handle = result_q;

	// the wave leaves the row only during a search
	a_wave_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		wave[TABLE_DEPTH].live |-> (state_q == S_SWEEP))
		else $error("search wave left the row outside a search");

	// a new result appears only after the finish step
	a_result_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result loaded outside the finish step");

	// an accepted item launches exactly one wave
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (launch_q && (state_q == S_SWEEP)))
		else $error("accepted item did not launch a search");

	// the table changes only when the result register can take the answer
	a_update_gated: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.strobe |=> (out_valid_q && (status_q == ST_OK)))
		else $error("table update without an ok result");

	// failed operations report handle zero
	a_fail_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != ST_OK)) |-> (result_q == '0))
		else $error("nonzero handle on a failed operation");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tcpct_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;
	localparam int QUIET_LIMIT = 3000;
	localparam int MAX_ITEMS = 2048;

	// one table operation as presented to the block
	typedef struct packed {
		op_t                 kind;
		key_t                ends;
		logic [HANDLE_W-1:0] handle;
		logic                drain;
	} conn_op_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
	} conn_res_t;

	// live flags, endpoints and recency ranks of every slot
	typedef struct packed {
		logic [DEPTH-1:0]               live;
		key_t [DEPTH-1:0]               ends;
		logic [DEPTH-1:0][HANDLE_W-1:0] rank;
	} conn_tab_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          kind = '0;
	logic [31:0]         src_ip = '0;
	logic [31:0]         dst_ip = '0;
	logic [15:0]         src_port = '0;
	logic [15:0]         dst_port = '0;
	logic [5:0]          close_handle = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] result_handle;

	conn_tab_t conn_tab = '0;
	conn_tab_t aim_tab = '0;
	conn_op_t  pend_q [$];
	conn_op_t  on_bus;
	conn_res_t expected_result [0:MAX_ITEMS-1];
	conn_res_t want;
	int        n_total = 0;
	int        n_sent = 0;
	int        n_checked = 0;
	int        n_errors = 0;
	int        outstanding;
	int        gap_left = 0;
	int        stall_left = 0;
	int        stall_len;
	int        quiet = 0;
	int        cycle_cnt = 0;
	int        peak_live = 0;
	int        tally [4][4];
	logic      calm;

	tcp_connection_table #(.TABLE_DEPTH(DEPTH)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.src_ip       (src_ip),
		.dst_ip       (dst_ip),
		.src_port     (src_port),
		.dst_port     (dst_port),
		.close_handle (close_handle),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_handle(result_handle)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// stretches with no idling on either side
	assign calm = (cycle_cnt % 5000) < 1000;

	function automatic key_t swap_ends(key_t k);
		key_t s;
		s.src_ip   = k.dst_ip;
		s.dst_ip   = k.src_ip;
		s.src_port = k.dst_port;
		s.dst_port = k.src_port;
		return s;
	endfunction

	function automatic key_t mk_key(logic [31:0] sip, logic [31:0] dip,
			logic [15:0] sp, logic [15:0] dp);
		key_t k;
		k.src_ip   = sip;
		k.dst_ip   = dip;
		k.src_port = sp;
		k.dst_port = dp;
		return k;
	endfunction

	function automatic key_t rand_key();
		key_t k;
		k = mk_key($urandom, $urandom, 16'($urandom), 16'($urandom));
		// push a field to an extreme now and then
		case ($urandom_range(0, 7))
			0: k.src_ip = '0;
			1: k.dst_ip = '1;
			2: k.src_port = '1;
			3: k.dst_port = '0;
			default: ;
		endcase
		return k;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	// applies one operation to a table copy and returns its result
	function automatic conn_res_t predict_conn_op(inout conn_tab_t t, input conn_op_t op);
		conn_res_t           r;
		int                  i;
		int                  slot;
		int                  best;
		logic [HANDLE_W-1:0] gone_rank;
		r.status = ST_OK;
		r.handle = '0;
		slot = -1;
		best = -1;
		case (op.kind)
			OP_INSERT: begin
				for (i = 0; i < DEPTH; i++)
					if (!t.live[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					// everyone ages by one, the newcomer is rank zero
					for (i = 0; i < DEPTH; i++)
						if (t.live[i])
							t.rank[i] = t.rank[i] + 1'b1;
					t.live[slot] = 1'b1;
					t.ends[slot] = op.ends;
					t.rank[slot] = '0;
					r.handle = HANDLE_W'(slot);
				end
			end
			OP_LOOKUP: begin
				// either direction matches, the newest match wins
				for (i = 0; i < DEPTH; i++)
					if (t.live[i] && (t.ends[i] == op.ends || t.ends[i] == swap_ends(op.ends))
							&& (best < 0 || t.rank[i] < t.rank[best]))
						best = i;
				if (best < 0)
					r.status = ST_MISS;
				else
					r.handle = HANDLE_W'(best);
			end
			OP_CLOSE: begin
				if (int'(op.handle) >= DEPTH || !t.live[op.handle]) begin
					r.status = ST_FREE;
				end else begin
					gone_rank = t.rank[op.handle];
					t.live[op.handle] = 1'b0;
					for (i = 0; i < DEPTH; i++)
						if (t.live[i] && t.rank[i] > gone_rank)
							t.rank[i] = t.rank[i] - 1'b1;
					r.handle = op.handle;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// queue an item and keep the aiming copy of the table in step
	task automatic push_op(op_t k, key_t ends, logic [HANDLE_W-1:0] h, logic drain);
		conn_op_t op;
		op.kind = k;
		op.ends = ends;
		op.handle = h;
		op.drain = drain;
		void'(predict_conn_op(aim_tab, op));
		pend_q.push_back(op);
		n_total++;
	endtask

	// random items aimed mostly at live connections
	task automatic gen_phase(int n, int w_ins, int w_look, int w_close, logic drain_first);
		int                  i;
		int                  s;
		int                  r;
		int                  pick;
		int                  flip;
		int                  live_q [$];
		key_t                k;
		logic [95:0]         flat;
		logic [HANDLE_W-1:0] h;
		op_t                 kd;
		for (i = 0; i < n; i++) begin
			live_q.delete();
			for (s = 0; s < DEPTH; s++)
				if (aim_tab.live[s])
					live_q.push_back(s);
			pick = live_q.size() > 0 ? live_q[$urandom_range(0, live_q.size() - 1)] : 0;
			k = rand_key();
			h = HANDLE_W'($urandom_range(0, DEPTH - 1));
			r = $urandom_range(0, 99);
			if (r < w_ins) begin
				kd = OP_INSERT;
				// repeat a live connection so lookups see several matches
				if (live_q.size() > 0 && $urandom_range(0, 4) == 0)
					k = $urandom_range(0, 1) ? aim_tab.ends[pick] : swap_ends(aim_tab.ends[pick]);
			end else if (r < w_ins + w_look) begin
				kd = OP_LOOKUP;
				if (live_q.size() > 0 && $urandom_range(0, 9) < 8) begin
					k = $urandom_range(0, 1) ? aim_tab.ends[pick] : swap_ends(aim_tab.ends[pick]);
					// near miss: one bit off
					if ($urandom_range(0, 9) == 0) begin
						flat = k;
						flip = $urandom_range(0, 95);
						flat[flip] = ~flat[flip];
						k = flat;
					end
				end
			end else if (r < w_ins + w_look + w_close) begin
				kd = OP_CLOSE;
				if (live_q.size() > 0 && $urandom_range(0, 9) < 8)
					h = HANDLE_W'(pick);
			end else begin
				kd = OP_NOP;
			end
			push_op(kd, k, h, drain_first && i == 0);
		end
	endtask

	task automatic build_stimulus();
		key_t zeros;
		key_t ones;
		key_t ka;
		key_t kb;
		zeros = '0;
		ones = '1;
		ka = mk_key(32'h0a00_0001, 32'hc0a8_0001, 16'd1234, 16'd80);
		kb = mk_key(32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001);
		// empty table: miss, closes of free slots, unused kind
		push_op(OP_LOOKUP, ones, 6'd0, 1'b0);
		push_op(OP_CLOSE, zeros, 6'd0, 1'b0);
		push_op(OP_CLOSE, ones, 6'd63, 1'b0);
		push_op(OP_NOP, ones, 6'd63, 1'b0);
		// extreme keys
		push_op(OP_INSERT, zeros, 6'd63, 1'b0);
		push_op(OP_INSERT, ones, 6'd0, 1'b0);
		push_op(OP_LOOKUP, zeros, 6'd0, 1'b0);
		push_op(OP_LOOKUP, ones, 6'd0, 1'b0);
		// forward, swapped and near-miss lookups
		push_op(OP_INSERT, ka, 6'd0, 1'b0);
		push_op(OP_LOOKUP, ka, 6'd0, 1'b0);
		push_op(OP_LOOKUP, swap_ends(ka), 6'd0, 1'b0);
		push_op(OP_LOOKUP, mk_key(ka.src_ip, ka.dst_ip, ka.src_port, 16'd81), 6'd0, 1'b0);
		// duplicates: the newest live one wins
		push_op(OP_INSERT, ka, 6'd0, 1'b0);
		push_op(OP_LOOKUP, swap_ends(ka), 6'd0, 1'b0);
		push_op(OP_INSERT, swap_ends(ka), 6'd0, 1'b0);
		push_op(OP_LOOKUP, ka, 6'd0, 1'b0);
		push_op(OP_CLOSE, zeros, 6'd4, 1'b0);
		push_op(OP_LOOKUP, swap_ends(ka), 6'd0, 1'b0);
		push_op(OP_CLOSE, zeros, 6'd3, 1'b0);
		push_op(OP_CLOSE, zeros, 6'd3, 1'b0);
		push_op(OP_LOOKUP, ka, 6'd0, 1'b0);
		// slot reuse: low slot but newest entry
		push_op(OP_INSERT, kb, 6'd0, 1'b0);
		push_op(OP_CLOSE, zeros, 6'd0, 1'b0);
		push_op(OP_INSERT, ka, 6'd0, 1'b0);
		push_op(OP_LOOKUP, ka, 6'd0, 1'b0);
		// fill up and hit the full table, drain it, then a balanced mix
		gen_phase(400, 55, 30, 10, 1'b1);
		gen_phase(330, 20, 30, 45, 1'b1);
		gen_phase(250, 33, 34, 28, 1'b1);
	endtask

	task automatic report_mismatch(string what, int seq, int got, int exp_val);
		if (n_errors < 30)
			$display("item %0d: %s is %0d, expected %0d", seq, what, got, exp_val);
		n_errors++;
	endtask

	// driver: predicts each item at acceptance, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
			n_sent <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_result[n_sent] = predict_conn_op(conn_tab, on_bus);
				tally[on_bus.kind][expected_result[n_sent].status] += 1;
				if ($countones(conn_tab.live) > peak_live)
					peak_live = $countones(conn_tab.live);
				n_sent <= n_sent + 1;
			end
			if (!(in_valid && in_stall)) begin
				outstanding = n_sent + (in_valid ? 1 : 0) - n_checked;
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pend_q.size() > 0 && !(pend_q[0].drain && outstanding != 0)) begin
					on_bus = pend_q.pop_front();
					kind <= on_bus.kind;
					src_ip <= on_bus.ends.src_ip;
					dst_ip <= on_bus.ends.dst_ip;
					src_port <= on_bus.ends.src_port;
					dst_port <= on_bus.ends.dst_port;
					close_handle <= on_bus.handle;
					in_valid <= 1'b1;
					gap_left <= calm ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stalls in runs of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			stall_len = (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
			out_stall <= stall_len > 0;
			stall_left <= stall_len > 0 ? stall_len - 1 : 0;
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_checked <= 0;
		end else if (out_valid && !out_stall) begin
			if (n_checked >= n_sent) begin
				report_mismatch("result with no item pending, status", n_checked, status, 0);
			end else begin
				want = expected_result[n_checked];
				if (status !== want.status)
					report_mismatch("status", n_checked, status, want.status);
				if (result_handle !== want.handle)
					report_mismatch("result_handle", n_checked, result_handle, want.handle);
				n_checked <= n_checked + 1;
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		build_stimulus();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (n_sent != n_total || n_checked != n_sent)
			@(posedge clk);
		repeat (2 * (DEPTH + 3)) @(posedge clk);
		$display("%0d items: %0d inserts, %0d refused as full, %0d lookup hits, %0d misses",
			n_sent, tally[OP_INSERT][ST_OK], tally[OP_INSERT][ST_FULL],
			tally[OP_LOOKUP][ST_OK], tally[OP_LOOKUP][ST_MISS]);
		$display("%0d closes, %0d closes of free slots, %0d no-ops, up to %0d live entries",
			tally[OP_CLOSE][ST_OK], tally[OP_CLOSE][ST_FREE], tally[OP_NOP][ST_OK], peak_live);
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
src/tcpct_pkg.sv
src/tcpct_cell.sv
src/tcp_connection_table.sv
bench/tb_top.sv
